@@ sv/qenc_pkg.sv @@
// Shared types and constants for the quadrature encoder with push button.
// Used by qenc_core and quadrature_encoder_with_button; no dependencies.
package qenc_pkg;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 20;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd50000;

    // operation field
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // switch level: low means pressed
    localparam logic SW_PRESSED = 1'b0;

    // A/B pair, A in the high bit
    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_10 = 2'b10;
    localparam logic [1:0] AB_11 = 2'b11;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CW1  = 3'd1,
        PH_CW2  = 3'd2,
        PH_CW3  = 3'd3,
        PH_CCW1 = 3'd4,
        PH_CCW2 = 3'd5,
        PH_CCW3 = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_CW     = 2'd2,
        EV_CCW    = 2'd3
    } event_t;

    typedef struct packed {
        logic              operation;
        logic              switch_level;
        logic              a_level;
        logic              b_level;
        logic [TIME_W-1:0] time_us;
    } item_t;

endpackage

@@ sv/qenc_core.sv @@
// Decoder state: rotation phase machine, press debounce and pending event.
// Depends on qenc_pkg. Updates once per stepped item; reports the pending event.
module qenc_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  qenc_pkg::item_t                  item,
    input  logic [qenc_pkg::DEBOUNCE_W-1:0]  debounce_time_us,
    output qenc_pkg::event_t                 held_event
);

    qenc_pkg::phase_t                  phase_reg, phase_next;
    qenc_pkg::event_t                  pending_reg, pending_next;
    logic [qenc_pkg::TIME_W-1:0]       last_press_reg, last_press_next;
    logic [qenc_pkg::TIME_W-1:0]       elapsed;
    logic [1:0]                        ab;
    logic                              press_ok;
    logic                              is_poll;
    logic                              is_press;
    qenc_pkg::event_t                  rot_event;

    assign ab       = {item.a_level, item.b_level};
    assign is_poll  = (item.operation == qenc_pkg::OP_POLL);
    assign is_press = (item.switch_level == qenc_pkg::SW_PRESSED);
    // modulo 2^32 difference handles timestamp wrap
    assign elapsed  = item.time_us - last_press_reg;
    assign press_ok = (elapsed >= {{(qenc_pkg::TIME_W-qenc_pkg::DEBOUNCE_W){1'b0}},
                                   debounce_time_us});

    // rotation machine: next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            qenc_pkg::PH_CW1: begin
                if (ab == qenc_pkg::AB_00)      phase_next = qenc_pkg::PH_CW2;
                else if (ab == qenc_pkg::AB_11) phase_next = qenc_pkg::PH_IDLE;
            end
            qenc_pkg::PH_CW2: begin
                if (ab == qenc_pkg::AB_10)      phase_next = qenc_pkg::PH_CW3;
                else if (ab == qenc_pkg::AB_11) phase_next = qenc_pkg::PH_IDLE;
            end
            qenc_pkg::PH_CW3: begin
                if (ab == qenc_pkg::AB_11)      phase_next = qenc_pkg::PH_IDLE;
            end
            qenc_pkg::PH_CCW1: begin
                if (ab == qenc_pkg::AB_00)      phase_next = qenc_pkg::PH_CCW2;
                else if (ab == qenc_pkg::AB_11) phase_next = qenc_pkg::PH_IDLE;
            end
            qenc_pkg::PH_CCW2: begin
                if (ab == qenc_pkg::AB_01)      phase_next = qenc_pkg::PH_CCW3;
                else if (ab == qenc_pkg::AB_11) phase_next = qenc_pkg::PH_IDLE;
            end
            qenc_pkg::PH_CCW3: begin
                if (ab == qenc_pkg::AB_11)      phase_next = qenc_pkg::PH_IDLE;
            end
            default: begin
                // idle, and the unused code acts as idle
                if (ab == qenc_pkg::AB_01)      phase_next = qenc_pkg::PH_CW1;
                else if (ab == qenc_pkg::AB_10) phase_next = qenc_pkg::PH_CCW1;
                else                            phase_next = qenc_pkg::PH_IDLE;
            end
        endcase
    end

    // rotation machine: completion event
    always_comb begin
        rot_event = qenc_pkg::EV_NONE;
        case (phase_reg)
            qenc_pkg::PH_CW3: begin
                if (ab == qenc_pkg::AB_11) rot_event = qenc_pkg::EV_CW;
            end
            qenc_pkg::PH_CCW3: begin
                if (ab == qenc_pkg::AB_11) rot_event = qenc_pkg::EV_CCW;
            end
            default: begin
                rot_event = qenc_pkg::EV_NONE;
            end
        endcase
    end

    always_comb begin
        pending_next    = pending_reg;
        last_press_next = last_press_reg;
        if (is_poll) begin
            pending_next = qenc_pkg::EV_NONE;
        end else if (is_press) begin
            if (press_ok) begin
                pending_next    = qenc_pkg::EV_BUTTON;
                last_press_next = item.time_us;
            end
        end else if (rot_event != qenc_pkg::EV_NONE) begin
            pending_next = rot_event;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= qenc_pkg::PH_IDLE;
            pending_reg    <= qenc_pkg::EV_NONE;
            last_press_reg <= '0;
        end else if (step_en) begin
            pending_reg    <= pending_next;
            last_press_reg <= last_press_next;
            // a press or a poll leaves the phase alone
            if (!is_poll && !is_press) begin
                phase_reg <= phase_next;
            end
        end
    end

    assign held_event = pending_reg;

endmodule

@@ sv/quadrature_encoder_with_button.sv @@
// Top level: quadrature encoder and push button event decoder.
// Depends on qenc_pkg and qenc_core; input register, decode, result register.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      operation, switch/A/B levels, time_us
//   m_       out        m_valid / m_ready      event_code (one per poll)
//   cfg_     in         cfg_valid / cfg_ready  debounce_time_us (20 bits)
//
// One item per cycle sustained unless a poll is held; each item passes through the input
// register, and a poll's result is written to the result register as the poll leaves it.
// Samples never stall. Only a poll waiting behind an untaken result holds the
// input register and drops s_ready. aresetn is synchronous and active low; it
// empties both registers and restores the reset state and debounce value.
module quadrature_encoder_with_button (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic                             s_switch_level,
    input  logic                             s_a_level,
    input  logic                             s_b_level,
    input  logic [qenc_pkg::TIME_W-1:0]      s_time_us,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_event_code,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qenc_pkg::DEBOUNCE_W-1:0]  cfg_data
);

    logic                              in_valid_reg;
    qenc_pkg::item_t                   in_item_reg;
    logic                              out_valid_reg;
    qenc_pkg::event_t                  out_event_reg;
    logic [qenc_pkg::DEBOUNCE_W-1:0]   debounce_reg;
    logic                              in_is_poll;
    logic                              advance;
    qenc_pkg::event_t                  held_event;

    assign in_is_poll = (in_item_reg.operation == qenc_pkg::OP_POLL);
    // a sample needs no result slot; a poll needs the result register free
    assign advance    = in_valid_reg && (!in_is_poll || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.operation    <= s_operation;
            in_item_reg.switch_level <= s_switch_level;
            in_item_reg.a_level      <= s_a_level;
            in_item_reg.b_level      <= s_b_level;
            in_item_reg.time_us      <= s_time_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= qenc_pkg::DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            debounce_reg <= cfg_data;
        end
    end

    qenc_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .item             (in_item_reg),
        .debounce_time_us (debounce_reg),
        .held_event       (held_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_is_poll) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_is_poll) begin
            out_event_reg <= held_event;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_event_reg;

endmodule

@@ sv/qenc_checker.sv @@
// Port-level checks for quadrature_encoder_with_button, bound to the top level.
// Standalone; watches only the handshake and result ports.
module qenc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [1:0]                       m_event_code,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    // a receiver that takes results never sees the input stalled
    a_ready_when_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the receiver was ready");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind quadrature_encoder_with_button qenc_checker u_qenc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_code (m_event_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

@@ dv/tb_quadrature_encoder_with_button.sv @@
// Testbench for quadrature_encoder_with_button: pin samples and polls in, events out.
// Uses qenc_pkg; an in-file scoreboard predicts each polled event and checks it in order.
module tb_quadrature_encoder_with_button;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 62;
    localparam int REPORT_MAX   = 10;

    typedef logic [qenc_pkg::TIME_W-1:0]     stamp_t;
    typedef logic [qenc_pkg::DEBOUNCE_W-1:0] dbnc_t;

    class event_scoreboard;
        dbnc_t                 debounce_us;
        stamp_t                last_press_us;
        qenc_pkg::phase_t      phase;
        qenc_pkg::event_t      pending;
        qenc_pkg::event_t      expected_events[$];
        int                    mismatches;
        int                    events_checked;
        int                    polls_seen;
        int                    presses_taken;
        int                    turns_done;

        function new();
            debounce_us    = qenc_pkg::DEBOUNCE_RESET;
            last_press_us  = '0;
            phase          = qenc_pkg::PH_IDLE;
            pending        = qenc_pkg::EV_NONE;
            mismatches     = 0;
            events_checked = 0;
            polls_seen     = 0;
            presses_taken  = 0;
            turns_done     = 0;
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
        endfunction

        function void note_input(logic op, logic sw, logic a, logic b, stamp_t t);
            logic [1:0] ab;
            stamp_t     elapsed;
            ab = {a, b};
            elapsed = t - last_press_us;
            if (op == qenc_pkg::OP_POLL) begin
                expected_events.push_back(pending);
                pending = qenc_pkg::EV_NONE;
                polls_seen++;
            end else if (sw == qenc_pkg::SW_PRESSED) begin
                // press bypasses the rotation machine; phase holds
                if (elapsed >= stamp_t'(debounce_us)) begin
                    last_press_us = t;
                    pending = qenc_pkg::EV_BUTTON;
                    presses_taken++;
                end
            end else begin
                case (phase)
                    qenc_pkg::PH_CW1: begin
                        if (ab == qenc_pkg::AB_00) phase = qenc_pkg::PH_CW2;
                        else if (ab == qenc_pkg::AB_11) phase = qenc_pkg::PH_IDLE;
                    end
                    qenc_pkg::PH_CW2: begin
                        if (ab == qenc_pkg::AB_10) phase = qenc_pkg::PH_CW3;
                        else if (ab == qenc_pkg::AB_11) phase = qenc_pkg::PH_IDLE;
                    end
                    qenc_pkg::PH_CW3: begin
                        if (ab == qenc_pkg::AB_11) begin
                            pending = qenc_pkg::EV_CW;
                            phase = qenc_pkg::PH_IDLE;
                            turns_done++;
                        end
                    end
                    qenc_pkg::PH_CCW1: begin
                        if (ab == qenc_pkg::AB_00) phase = qenc_pkg::PH_CCW2;
                        else if (ab == qenc_pkg::AB_11) phase = qenc_pkg::PH_IDLE;
                    end
                    qenc_pkg::PH_CCW2: begin
                        if (ab == qenc_pkg::AB_01) phase = qenc_pkg::PH_CCW3;
                        else if (ab == qenc_pkg::AB_11) phase = qenc_pkg::PH_IDLE;
                    end
                    qenc_pkg::PH_CCW3: begin
                        if (ab == qenc_pkg::AB_11) begin
                            pending = qenc_pkg::EV_CCW;
                            phase = qenc_pkg::PH_IDLE;
                            turns_done++;
                        end
                    end
                    default: begin
                        if (ab == qenc_pkg::AB_01) phase = qenc_pkg::PH_CW1;
                        else if (ab == qenc_pkg::AB_10) phase = qenc_pkg::PH_CCW1;
                        else phase = qenc_pkg::PH_IDLE;
                    end
                endcase
            end
        endfunction

        function void check_result(logic [1:0] code);
            qenc_pkg::event_t want;
            if (expected_events.size() == 0) begin
                flag($sformatf("event_code %0d with no poll outstanding", code));
            end else begin
                want = expected_events.pop_front();
                events_checked++;
                if (code !== want) begin
                    flag($sformatf("event_code expected %0d (%s) got %0d",
                                   want, want.name(), code));
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic                  s_switch_level;
    logic                  s_a_level;
    logic                  s_b_level;
    stamp_t                s_time_us;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_event_code;
    logic                  cfg_valid;
    logic                  cfg_ready;
    dbnc_t                 cfg_data;

    event_scoreboard sb = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit holdoff_go         = 1'b0;
    int holds_done         = 0;
    int items_sent         = 0;
    int settings_used      = 1;
    int quiet_cycles       = 0;

    quadrature_encoder_with_button dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_switch_level (s_switch_level),
        .s_a_level      (s_a_level),
        .s_b_level      (s_b_level),
        .s_time_us      (s_time_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_code   (m_event_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    // no-progress watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d events outstanding",
                     STALL_LIMIT, sb.outstanding());
            $display("quadrature_encoder_with_button verification failed");
            $finish;
        end
    end

    // result side: check accepted items, then pick next m_ready
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_event_code);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holdoff_go) begin
                holdoff_go = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    task automatic send_item(input logic op, input logic sw, input logic a, input logic b,
                             input stamp_t t);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_switch_level <= sw;
        s_a_level      <= a;
        s_b_level      <= b;
        s_time_us      <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, sw, a, b, t);
        items_sent++;
    endtask

    task automatic send_ab(input logic [1:0] ab);
        send_item(qenc_pkg::OP_SAMPLE, ~qenc_pkg::SW_PRESSED, ab[1], ab[0], $urandom());
    endtask

    task automatic send_poll();
        send_item(qenc_pkg::OP_POLL, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                  $urandom());
    endtask

    // press times cluster around the debounce boundary, with some spread and some noise
    task automatic press_button();
        int unsigned pick;
        stamp_t      t;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            t = stamp_t'(sb.last_press_us + sb.debounce_us + $urandom_range(0, 4) - 2);
        end else if (pick < 7) begin
            t = stamp_t'(sb.last_press_us + $urandom_range(0, 2 * sb.debounce_us + 1));
        end else begin
            t = $urandom();
        end
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'($urandom()),
                  1'($urandom()), t);
    endtask

    // one detent with repeated samples, occasional bounce back to 11 and stray presses
    task automatic send_rotation(input bit clockwise);
        logic [1:0] steps [4];
        int         extra;
        if (clockwise) begin
            steps[0] = qenc_pkg::AB_01; steps[1] = qenc_pkg::AB_00;
            steps[2] = qenc_pkg::AB_10; steps[3] = qenc_pkg::AB_11;
        end else begin
            steps[0] = qenc_pkg::AB_10; steps[1] = qenc_pkg::AB_00;
            steps[2] = qenc_pkg::AB_01; steps[3] = qenc_pkg::AB_11;
        end
        for (int i = 0; i < 4; i++) begin
            extra = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2) : 0;
            repeat (extra + 1) send_ab(steps[i]);
            if (i > 0 && i < 3 && $urandom_range(0, 99) < 12) send_ab(qenc_pkg::AB_11);
            if ($urandom_range(0, 99) < 10) press_button();
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_poll();
            end else if (pick < 48) begin
                send_rotation(1'b1);
            end else if (pick < 68) begin
                send_rotation(1'b0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3)) press_button();
            end else begin
                send_item(qenc_pkg::OP_SAMPLE, 1'($urandom()), 1'($urandom()),
                          1'($urandom()), $urandom());
            end
        end
    endtask

    // samples leave no result, so wait out the pipeline after the last event
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_debounce(input dbnc_t value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.debounce_us = value;
        settings_used++;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = qenc_pkg::OP_SAMPLE;
        s_switch_level = ~qenc_pkg::SW_PRESSED;
        s_a_level      = 1'b1;
        s_b_level      = 1'b1;
        s_time_us      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first-press debounce from time zero, then exact boundary
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'b1, 1'b1, stamp_t'(49999));
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'b1, 1'b1, stamp_t'(50000));
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'b0, 1'b0, stamp_t'(99999));
        send_poll();
        // poll fields are don't-care
        send_item(qenc_pkg::OP_POLL, qenc_pkg::SW_PRESSED, 1'b1, 1'b1, '1);
        send_ab(qenc_pkg::AB_01); send_ab(qenc_pkg::AB_00);
        send_ab(qenc_pkg::AB_10); send_ab(qenc_pkg::AB_11);
        send_poll();
        send_ab(qenc_pkg::AB_10); send_ab(qenc_pkg::AB_00);
        send_ab(qenc_pkg::AB_01); send_ab(qenc_pkg::AB_11);
        send_poll();
        // bounce to idle, then a press mid-turn that the turn overwrites
        send_ab(qenc_pkg::AB_01); send_ab(qenc_pkg::AB_11);
        send_ab(qenc_pkg::AB_01);
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'b0, 1'b1, '1);
        send_ab(qenc_pkg::AB_00); send_ab(qenc_pkg::AB_10); send_ab(qenc_pkg::AB_11);
        send_poll();
        // timestamp wrap: exactly debounce after the press at all-ones
        send_item(qenc_pkg::OP_SAMPLE, qenc_pkg::SW_PRESSED, 1'b1, 1'b0, stamp_t'(49999));
        send_poll();

        run_random(PHASE_ITEMS);

        sender_idle_pct = 84;
        receiver_stall_pct = 0;
        write_debounce('0);
        run_random(PHASE_ITEMS);

        sender_idle_pct = 0;
        receiver_stall_pct = 84;
        write_debounce(dbnc_t'(1000000));
        holdoff_go = 1'b1;
        repeat (8) send_poll();
        run_random(PHASE_ITEMS);

        sender_idle_pct = 27;
        receiver_stall_pct = 27;
        write_debounce('1);
        run_random(PHASE_ITEMS);

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_debounce(dbnc_t'($urandom_range(1, 300)));
        run_random(PHASE_ITEMS);

        sender_idle_pct = 27;
        receiver_stall_pct = 84;
        write_debounce(dbnc_t'($urandom()));
        run_random(PHASE_ITEMS);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d polls) across %0d debounce settings and five idle mixes;",
                 items_sent, sb.polls_seen, settings_used);
        $display("checked %0d events: %0d presses taken, %0d full turns, %0d long hold-offs.",
                 sb.events_checked, sb.presses_taken, sb.turns_done, holds_done);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("quadrature_encoder_with_button verification clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("quadrature_encoder_with_button verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/qenc_pkg.sv
sv/qenc_core.sv
sv/quadrature_encoder_with_button.sv
sv/qenc_checker.sv
dv/tb_quadrature_encoder_with_button.sv
